FILE: hdl/utf8vd_pkg.sv
// Shared constants and types for the UTF-8 validating decoder.
`timescale 1ns / 1ps
package utf8vd_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int BYTE_W   = 8;
  localparam int SCALAR_W = 21;
  localparam int LEAD_W   = 32;
  localparam int OUT_TDATA_W = ((SCALAR_W + LEAD_W + 7) / 8) * 8;

  localparam logic [SCALAR_W-1:0] REPL_CHAR  = 21'h00FFFD;
  localparam logic [SCALAR_W-1:0] MAX_SCALAR = 21'h10FFFF;
  localparam logic [SCALAR_W-1:0] SURR_LO    = 21'h00D800;
  localparam logic [SCALAR_W-1:0] SURR_HI    = 21'h00DFFF;
  localparam logic [SCALAR_W-1:0] MIN_TWO    = 21'h000080;
  localparam logic [SCALAR_W-1:0] MIN_THREE  = 21'h000800;
  localparam logic [SCALAR_W-1:0] MIN_FOUR   = 21'h010000;

  localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hF4;

  // One queued job: replacement run followed by an optional single result.
  typedef struct packed {
    logic [2:0]          rep_cnt;
    logic                tail_vld;
    logic                tail_repl;
    logic [SCALAR_W-1:0] tail_val;
  } job_ctl_t;

  localparam int JOB_CTL_W = $bits(job_ctl_t);

endpackage

FILE: hdl/utf8vd_front.sv
// Front end: accepts bytes, tracks the open sequence and forms result jobs.
`timescale 1ns / 1ps
module utf8vd_front #(
  parameter int OFFSET_BITS = utf8vd_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_acc,
  input  logic [utf8vd_pkg::BYTE_W-1:0]   text_byte,
  input  logic                            final_byte,
  output logic                            job_push,
  output utf8vd_pkg::job_ctl_t            job_ctl,
  output logic [OFFSET_BITS-1:0]          job_rep_start,
  output logic [OFFSET_BITS-1:0]          job_tail_off
);
  import utf8vd_pkg::*;

  logic [SCALAR_W-1:0]    partial_r, partial_nxt;
  logic [1:0]             need_r, need_nxt;
  logic [1:0]             len_r, len_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;

  logic                is_cont;
  logic [SCALAR_W-1:0] cat_val;
  logic [SCALAR_W-1:0] min_val;
  logic                bad_val;
  logic                lead_ascii;
  logic                lead_multi;
  logic [1:0]          lead_cnt;
  logic [SCALAR_W-1:0] lead_bits;
  logic                do_lead;
  logic [1:0]          need_dec;

  always_comb begin
    lead_ascii = (text_byte[7] == 1'b0);
    lead_multi = 1'b1;
    lead_cnt   = 2'd0;
    lead_bits  = '0;
    priority if (text_byte >= LEAD2_LO && text_byte <= LEAD2_HI) begin
      lead_cnt  = 2'd1;
      lead_bits = {16'b0, text_byte[4:0]};
    end else if (text_byte >= LEAD3_LO && text_byte <= LEAD3_HI) begin
      lead_cnt  = 2'd2;
      lead_bits = {17'b0, text_byte[3:0]};
    end else if (text_byte >= LEAD4_LO && text_byte <= LEAD4_HI) begin
      lead_cnt  = 2'd3;
      lead_bits = {18'b0, text_byte[2:0]};
    end else begin
      lead_multi = 1'b0;
    end
  end

  assign is_cont  = (text_byte[7:6] == 2'b10);
  assign cat_val  = {partial_r[SCALAR_W-7:0], text_byte[5:0]};
  assign need_dec = need_r - 2'd1;

  always_comb begin
    unique case (len_r)
      2'd1:    min_val = MIN_TWO;
      2'd2:    min_val = MIN_THREE;
      default: min_val = MIN_FOUR;
    endcase
  end

  assign bad_val = (cat_val < min_val) || (cat_val > MAX_SCALAR) ||
                   (cat_val >= SURR_LO && cat_val <= SURR_HI);

  always_comb begin
    partial_nxt = partial_r;
    need_nxt    = need_r;
    len_nxt     = len_r;
    start_nxt   = start_r;
    pos_nxt     = pos_r;
    job_ctl     = '0;
    job_tail_off = pos_r;
    do_lead     = 1'b0;

    if (need_r == 2'd0) begin
      do_lead = 1'b1;
    end else if (is_cont) begin
      partial_nxt = cat_val;
      need_nxt    = need_dec;
      if (need_dec == 2'd0) begin
        if (bad_val) begin
          job_ctl.rep_cnt = 3'd1 + {1'b0, len_r};
        end else begin
          job_ctl.tail_vld = 1'b1;
          job_ctl.tail_val = cat_val;
          job_tail_off     = start_r;
        end
        partial_nxt = '0;
        len_nxt     = 2'd0;
      end else if (final_byte) begin
        job_ctl.rep_cnt = 3'd1 + {1'b0, len_r - need_dec};
      end
    end else begin
      job_ctl.rep_cnt = 3'd1 + {1'b0, len_r - need_r};
      partial_nxt     = '0;
      need_nxt        = 2'd0;
      len_nxt         = 2'd0;
      do_lead         = 1'b1;
    end

    if (do_lead) begin
      priority if (lead_ascii) begin
        job_ctl.tail_vld = 1'b1;
        job_ctl.tail_val = {13'b0, text_byte};
      end else if (lead_multi && !final_byte) begin
        partial_nxt = lead_bits;
        need_nxt    = lead_cnt;
        len_nxt     = lead_cnt;
        start_nxt   = pos_r;
      end else begin
        job_ctl.tail_vld  = 1'b1;
        job_ctl.tail_repl = 1'b1;
        job_ctl.tail_val  = REPL_CHAR;
      end
    end

    if (final_byte) begin
      partial_nxt = '0;
      need_nxt    = 2'd0;
      len_nxt     = 2'd0;
      pos_nxt     = '0;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  assign job_rep_start = start_r;
  assign job_push      = in_acc && (job_ctl.rep_cnt != 3'd0 || job_ctl.tail_vld);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      need_r    <= 2'd0;
      len_r     <= 2'd0;
      start_r   <= '0;
      pos_r     <= '0;
    end else if (in_acc) begin
      partial_r <= partial_nxt;
      need_r    <= need_nxt;
      len_r     <= len_nxt;
      start_r   <= start_nxt;
      pos_r     <= pos_nxt;
    end
  end

endmodule

FILE: hdl/utf8vd_queue.sv
// Job queue between the front end and the result sequencer.
`timescale 1ns / 1ps
module utf8vd_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = utf8vd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              pop,
  output logic [DATA_W-1:0] rd_data,
  output logic              full,
  output logic              not_empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: hdl/utf8vd_back.sv
// Back end: expands queued jobs into results, one per cycle while res_ready is high, into the output register.
`timescale 1ns / 1ps
module utf8vd_back #(
  parameter int OFFSET_BITS = utf8vd_pkg::OFFSET_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               job_avail,
  input  utf8vd_pkg::job_ctl_t               job_ctl,
  input  logic [OFFSET_BITS-1:0]             job_rep_start,
  input  logic [OFFSET_BITS-1:0]             job_tail_off,
  output logic                               job_pop,
  output logic                               res_valid,
  input  logic                               res_ready,
  output logic [utf8vd_pkg::SCALAR_W-1:0]    res_scalar,
  output logic [utf8vd_pkg::LEAD_W-1:0]      res_offset,
  output logic                               res_repl,
  output logic                               res_last
);
  import utf8vd_pkg::*;

  logic [1:0]             idx_r, idx_nxt;
  logic                   valid_r, valid_nxt;
  logic [SCALAR_W-1:0]    scalar_r;
  logic [LEAD_W-1:0]      offset_r;
  logic                   repl_r;
  logic                   last_r;

  logic                       load;
  logic [2:0]                 res_cnt;
  logic                       is_rep;
  logic                       is_last;
  logic [OFFSET_BITS-1:0]     rep_off;
  logic [OFFSET_BITS-1:0]     sel_off;
  logic [OFFSET_BITS+LEAD_W-1:0] off_ext;
  logic [SCALAR_W-1:0]        sel_scalar;
  logic                       sel_repl;

  assign load    = job_avail && (!valid_r || res_ready);
  assign res_cnt = job_ctl.rep_cnt + {2'b0, job_ctl.tail_vld};
  assign is_rep  = ({1'b0, idx_r} < job_ctl.rep_cnt);
  assign is_last = ({1'b0, idx_r} + 3'd1 == res_cnt);
  assign rep_off = job_rep_start + {{(OFFSET_BITS-2){1'b0}}, idx_r};
  assign sel_off = is_rep ? rep_off : job_tail_off;
  assign off_ext = {{LEAD_W{1'b0}}, sel_off};
  assign sel_scalar = is_rep ? REPL_CHAR : job_ctl.tail_val;
  assign sel_repl   = is_rep ? 1'b1 : job_ctl.tail_repl;
  assign job_pop    = load && is_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = is_last ? 2'd0 : idx_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (res_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      scalar_r <= sel_scalar;
      offset_r <= off_ext[LEAD_W-1:0];
      repl_r   <= sel_repl;
      last_r   <= is_last;
    end
  end

  assign res_valid  = valid_r;
  assign res_scalar = scalar_r;
  assign res_offset = offset_r;
  assign res_repl   = repl_r;
  assign res_last   = last_r;

endmodule

FILE: hdl/utf8_validating_decoder.sv
// Top level of the streaming validating UTF-8 decoder.
//
// Input stream: one text byte per item in in_tdata[7:0]; in_tlast marks the
// final byte of a text, after which the byte offset restarts at zero.
// Output stream: one decoded scalar per item; out_tuser is set when the scalar
// is a U+FFFD replacement for malformed input, out_tlast on the last result
// caused by an input byte. A byte that leaves a sequence open gives nothing.
// Path: a byte's job is written into the job queue when the byte is accepted,
// and its results then pass through the output register.
// Throughput: one byte per cycle while each byte gives at most one result,
// as for well-formed text, and out_tready stays high. A byte giving more than
// one result (up to four) holds the result sequencer while it emits them; the
// job queue of QUEUE_DEPTH entries absorbs such bursts before in_tready drops.
// Reset: clears the open sequence, the byte offset, the job queue and the
// output register; in_tready is high in the first cycle after reset.
// Stall: while out_tready is low the output item holds, the queue fills and
// then in_tready falls until results are taken again.
`timescale 1ns / 1ps
module utf8_validating_decoder #(
  parameter int OFFSET_BITS = utf8vd_pkg::OFFSET_BITS_DEF,
  parameter int QUEUE_DEPTH = utf8vd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // [7:0] text_byte
  input  logic                                 in_tlast,   // final_byte
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [utf8vd_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [20:0] scalar_value,
                                                           // [52:21] lead_offset
  output logic                                 out_tuser,  // was_replaced
  output logic                                 out_tlast   // end_of_run
);
  import utf8vd_pkg::*;

  localparam int JOB_W = JOB_CTL_W + 2 * OFFSET_BITS;

  logic                   in_acc;
  logic                   job_push;
  job_ctl_t               push_ctl;
  logic [OFFSET_BITS-1:0] push_rep_start;
  logic [OFFSET_BITS-1:0] push_tail_off;
  logic                   q_full;
  logic                   q_not_empty;
  logic                   job_pop;
  logic [JOB_W-1:0]       q_rd_data;
  job_ctl_t               head_ctl;
  logic [OFFSET_BITS-1:0] head_rep_start;
  logic [OFFSET_BITS-1:0] head_tail_off;
  logic [SCALAR_W-1:0]    res_scalar;
  logic [LEAD_W-1:0]      res_offset;

  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  utf8vd_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_acc        (in_acc),
    .text_byte     (in_tdata),
    .final_byte    (in_tlast),
    .job_push      (job_push),
    .job_ctl       (push_ctl),
    .job_rep_start (push_rep_start),
    .job_tail_off  (push_tail_off)
  );

  utf8vd_queue #(
    .DATA_W (JOB_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .wr_data   ({push_ctl, push_rep_start, push_tail_off}),
    .pop       (job_pop),
    .rd_data   (q_rd_data),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  assign {head_ctl, head_rep_start, head_tail_off} = q_rd_data;

  utf8vd_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_avail     (q_not_empty),
    .job_ctl       (head_ctl),
    .job_rep_start (head_rep_start),
    .job_tail_off  (head_tail_off),
    .job_pop       (job_pop),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res_scalar    (res_scalar),
    .res_offset    (res_offset),
    .res_repl      (out_tuser),
    .res_last      (out_tlast)
  );

  assign out_tdata = {{(OUT_TDATA_W - SCALAR_W - LEAD_W){1'b0}}, res_offset, res_scalar};

endmodule

FILE: hdl/utf8vd_checker.sv
// Port-level checks on the decoder's result stream, bound to the top level.
`timescale 1ns / 1ps
module utf8vd_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [utf8vd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                               out_tuser,
  input logic                               out_tlast
);
  import utf8vd_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_scalar_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[SCALAR_W-1:0] <= MAX_SCALAR)
    else $error("scalar above U+10FFFF");

  a_no_surrogate: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[SCALAR_W-1:0] >= SURR_LO &&
                     out_tdata[SCALAR_W-1:0] <= SURR_HI))
    else $error("surrogate scalar emitted");

  a_repl_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[SCALAR_W-1:0] == REPL_CHAR)
    else $error("replacement flag without U+FFFD");

endmodule

bind utf8_validating_decoder utf8vd_checker u_utf8vd_checker (.*);

FILE: test/testbench.sv
// Self-checking stream testbench for the validating UTF-8 decoder.
`timescale 1ns / 1ps
module testbench;
  import utf8vd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 80;

  typedef struct packed {
    logic [SCALAR_W-1:0] scalar;
    logic [LEAD_W-1:0]   lead_off;
    logic                replaced;
    logic                run_end;
  } decoded_t;

  typedef struct packed {
    logic [7:0]          text_byte;
    logic                fin;
    logic                hand;
    logic [SCALAR_W-1:0] scalar;
    logic [LEAD_W-1:0]   lead_off;
    logic                replaced;
  } text_row_t;

  localparam text_row_t DIRECTED_TEXT [24] = '{
    '{8'h7F, 1'b0, 1'b1, 21'h00007F, 32'd0,  1'b0},
    '{8'hC2, 1'b0, 1'b0, 21'h0,      32'd0,  1'b0},
    '{8'h80, 1'b0, 1'b1, 21'h000080, 32'd1,  1'b0},
    '{8'hEF, 1'b0, 1'b0, 21'h0,      32'd0,  1'b0},
    '{8'hBF, 1'b0, 1'b0, 21'h0,      32'd0,  1'b0},
    '{8'hBD, 1'b0, 1'b1, 21'h00FFFD, 32'd3,  1'b0},
    '{8'hF4, 1'b0, 1'b0, 21'h0,      32'd0,  1'b0},
    '{8'h8F, 1'b0, 1'b0, 21'h0,      32'd0,  1'b0},
    '{8'hBF, 1'b0, 1'b0, 21'h0,      32'd0,  1'b0},
    '{8'hBF, 1'b0, 1'b1, 21'h10FFFF, 32'd6,  1'b0},
    '{8'hFF, 1'b0, 1'b1, 21'h00FFFD, 32'd10, 1'b1},
    '{8'hE0, 1'b0, 1'b0, 21'h0,      32'd0,  1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0,      32'd0,  1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0,      32'd0,  1'b0},
    '{8'hF4, 1'b0, 1'b0, 21'h0,      32'd0,  1'b0},
    '{8'h90, 1'b0, 1'b0, 21'h0,      32'd0,  1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0,      32'd0,  1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0,      32'd0,  1'b0},
    '{8'hE2, 1'b0, 1'b0, 21'h0,      32'd0,  1'b0},
    '{8'h41, 1'b0, 1'b0, 21'h0,      32'd0,  1'b0},
    '{8'hE2, 1'b0, 1'b0, 21'h0,      32'd0,  1'b0},
    '{8'h82, 1'b1, 1'b0, 21'h0,      32'd0,  1'b0},
    '{8'hF0, 1'b1, 1'b1, 21'h00FFFD, 32'd0,  1'b1},
    '{8'h00, 1'b0, 1'b1, 21'h000000, 32'd0,  1'b0}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_go = 1'b0;
  int hold_cycles = 0;
  int cycle_count = 0;
  int mismatch_count = 0;

  decoded_t expected_scalars[$];
  decoded_t step_scalars[$];

  logic [SCALAR_W-1:0] acc_bits;
  logic [1:0]          need_cnt;
  logic [1:0]          seq_cnt;
  logic [LEAD_W-1:0]   seq_off;
  logic [LEAD_W-1:0]   pos_cnt;

  utf8_validating_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void put_scalar(logic [SCALAR_W-1:0] v, logic [LEAD_W-1:0] off,
                                     logic repl);
    decoded_t d;
    d.scalar   = v;
    d.lead_off = off;
    d.replaced = repl;
    d.run_end  = 1'b0;
    step_scalars.insert(step_scalars.size(), d);
  endfunction

  // FFFD for the open lead, then one per continuation byte already taken
  function automatic void reject_sequence();
    logic [1:0] taken;
    int k;
    taken = seq_cnt - need_cnt;
    put_scalar(REPL_CHAR, seq_off, 1'b1);
    for (k = 1; k <= taken; k++)
      put_scalar(REPL_CHAR, seq_off + LEAD_W'(k), 1'b1);
    need_cnt = 2'd0;
    seq_cnt  = 2'd0;
    acc_bits = '0;
  endfunction

  function automatic void open_lead(logic [7:0] b, logic fin, logic [LEAD_W-1:0] pos);
    logic [1:0]          cnt;
    logic [SCALAR_W-1:0] bits;
    cnt  = 2'd0;
    bits = '0;
    if (b < 8'h80) begin
      put_scalar({13'd0, b}, pos, 1'b0);
    end else begin
      if (b >= LEAD2_LO && b <= LEAD2_HI) begin
        cnt  = 2'd1;
        bits = {16'd0, b[4:0]};
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
        cnt  = 2'd2;
        bits = {17'd0, b[3:0]};
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
        cnt  = 2'd3;
        bits = {18'd0, b[2:0]};
      end
      if (cnt == 2'd0 || fin) begin
        put_scalar(REPL_CHAR, pos, 1'b1);
      end else begin
        acc_bits = bits;
        need_cnt = cnt;
        seq_cnt  = cnt;
        seq_off  = pos;
      end
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic fin);
    logic [LEAD_W-1:0]   pos;
    logic [SCALAR_W-1:0] floor_val;
    pos = pos_cnt;
    step_scalars.delete();
    if (need_cnt == 2'd0) begin
      open_lead(b, fin, pos);
    end else if (b[7:6] == 2'b10) begin
      acc_bits = {acc_bits[SCALAR_W-7:0], b[5:0]};
      need_cnt = need_cnt - 2'd1;
      if (need_cnt == 2'd0) begin
        floor_val = (seq_cnt == 2'd1) ? MIN_TWO : (seq_cnt == 2'd2) ? MIN_THREE : MIN_FOUR;
        if (acc_bits < floor_val || acc_bits > MAX_SCALAR ||
            (acc_bits >= SURR_LO && acc_bits <= SURR_HI)) begin
          reject_sequence();
        end else begin
          put_scalar(acc_bits, seq_off, 1'b0);
          seq_cnt  = 2'd0;
          acc_bits = '0;
        end
      end else if (fin) begin
        reject_sequence();
      end
    end else begin
      reject_sequence();
      open_lead(b, fin, pos);
    end
    if (fin) begin
      need_cnt = 2'd0;
      seq_cnt  = 2'd0;
      acc_bits = '0;
      pos_cnt  = '0;
    end else begin
      pos_cnt = pos_cnt + 1'b1;
    end
    if (step_scalars.size() > 0)
      step_scalars[step_scalars.size()-1].run_end = 1'b1;
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_byte(input logic [7:0] b, input logic fin, input logic hand,
                           input decoded_t hand_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = fin;
    do @(posedge clk); while (!in_tready);
    decode_byte(b, fin);
    if (hand)
      expected_scalars.insert(expected_scalars.size(), hand_res);
    else
      foreach (step_scalars[i]) expected_scalars.insert(expected_scalars.size(), step_scalars[i]);
    @(negedge clk);
  endtask

  task automatic send_random_text(input int n_items);
    int sent;
    int kind;
    int len;
    int cut;
    logic [SCALAR_W-1:0] cp;
    logic [7:0] seq[$];
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      len  = $urandom_range(4, 1);
      seq.delete();
      if (kind < 15) begin
        seq.insert(seq.size(), 8'($urandom_range(255)));
      end else begin
        case (len)
          1: cp = SCALAR_W'($urandom_range(21'h7F));
          2: cp = (kind < 30) ? SCALAR_W'($urandom_range(21'h7F)) :
                                SCALAR_W'($urandom_range(21'h7FF, 21'h80));
          3: cp = (kind < 22) ? SCALAR_W'($urandom_range(21'h7FF)) :
                  (kind < 30) ? SCALAR_W'($urandom_range(SURR_HI, SURR_LO)) :
                                SCALAR_W'($urandom_range(21'hFFFF, MIN_THREE));
          default: cp = (kind < 22) ? SCALAR_W'($urandom_range(21'hFFFF)) :
                        (kind < 30) ? SCALAR_W'($urandom_range(21'h13FFFF, 21'h110000)) :
                                      SCALAR_W'($urandom_range(MAX_SCALAR, MIN_FOUR));
        endcase
        case (len)
          1: seq.insert(seq.size(), cp[7:0]);
          2: begin
            seq.insert(seq.size(), {3'b110, cp[10:6]});
            seq.insert(seq.size(), {2'b10, cp[5:0]});
          end
          3: begin
            seq.insert(seq.size(), {4'b1110, cp[15:12]});
            seq.insert(seq.size(), {2'b10, cp[11:6]});
            seq.insert(seq.size(), {2'b10, cp[5:0]});
          end
          default: begin
            seq.insert(seq.size(), {5'b11110, cp[20:18]});
            seq.insert(seq.size(), {2'b10, cp[17:12]});
            seq.insert(seq.size(), {2'b10, cp[11:6]});
            seq.insert(seq.size(), {2'b10, cp[5:0]});
          end
        endcase
        // break the sequence early with an arbitrary byte
        if (kind >= 30 && kind < 45 && len > 1) begin
          cut = $urandom_range(len - 1, 1);
          while (seq.size() > cut) void'(seq.pop_back());
          seq.insert(seq.size(), 8'($urandom_range(255)));
        end
      end
      foreach (seq[i]) begin
        send_byte(seq[i], $urandom_range(24) == 0, 1'b0, '0);
        sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_go && hold_cycles < HOLD_OFF_CYCLES) begin
      out_tready = 1'b0;
      hold_cycles++;
    end else begin
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_scalars.size() == 0) begin
        $error("unexpected result: scalar_value %h lead_offset %0d",
               out_tdata[SCALAR_W-1:0], out_tdata[SCALAR_W+LEAD_W-1:SCALAR_W]);
        mismatch_count++;
      end else begin
        want = expected_scalars.pop_front();
        if (out_tdata[SCALAR_W-1:0] !== want.scalar) begin
          $error("scalar_value: expected %h, got %h", want.scalar, out_tdata[SCALAR_W-1:0]);
          mismatch_count++;
        end
        if (out_tdata[SCALAR_W+LEAD_W-1:SCALAR_W] !== want.lead_off) begin
          $error("lead_offset: expected %0d, got %0d", want.lead_off,
                 out_tdata[SCALAR_W+LEAD_W-1:SCALAR_W]);
          mismatch_count++;
        end
        if (out_tuser !== want.replaced) begin
          $error("was_replaced: expected %b, got %b", want.replaced, out_tuser);
          mismatch_count++;
        end
        if (out_tlast !== want.run_end) begin
          $error("end_of_run: expected %b, got %b", want.run_end, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    decoded_t hand_res;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    acc_bits  = '0;
    need_cnt  = 2'd0;
    seq_cnt   = 2'd0;
    seq_off   = '0;
    pos_cnt   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (DIRECTED_TEXT[i]) begin
      hand_res.scalar   = DIRECTED_TEXT[i].scalar;
      hand_res.lead_off = DIRECTED_TEXT[i].lead_off;
      hand_res.replaced = DIRECTED_TEXT[i].replaced;
      hand_res.run_end  = 1'b1;
      send_byte(DIRECTED_TEXT[i].text_byte, DIRECTED_TEXT[i].fin, DIRECTED_TEXT[i].hand,
                hand_res);
    end

    send_random_text(40);
    send_idle_pct = 81;
    send_random_text(30);
    send_idle_pct  = 0;
    recv_stall_pct = 81;
    send_random_text(30);
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    send_random_text(30);
    // long receiver hold-off while the sender keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go        = 1'b1;
    send_random_text(25);
    in_tvalid = 1'b0;

    while (expected_scalars.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

FILE: sim.f
hdl/utf8vd_pkg.sv
hdl/utf8vd_front.sv
hdl/utf8vd_queue.sv
hdl/utf8vd_back.sv
hdl/utf8_validating_decoder.sv
hdl/utf8vd_checker.sv
test/testbench.sv
